/* hw/rtl/lcrs_pkg.sv */
// lcrs_pkg: shared types and codes for the command record store
// no dependencies
package lcrs_pkg;
	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] data_byte;
		logic       last_byte;
		logic [6:0] code_value;
		logic [7:0] record_number;
		logic       delete_all;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        event_kind;
		logic signed [7:0] event_code;
		logic [7:0]        out_byte;
		logic              last_out;
	} out_item_t;

	localparam logic [2:0] MODE_BYTE   = 3'd0;
	localparam logic [2:0] MODE_START  = 3'd1;
	localparam logic [2:0] MODE_DELETE = 3'd2;
	localparam logic [2:0] MODE_REPLAY = 3'd3;
	localparam logic [2:0] MODE_TICK   = 3'd4;

	localparam logic [2:0] EV_OK       = 3'd0;
	localparam logic [2:0] EV_FULL     = 3'd1;
	localparam logic [2:0] EV_DUP      = 3'd2;
	localparam logic [2:0] EV_TIMEOUT  = 3'd3;
	localparam logic [2:0] EV_NOTFOUND = 3'd4;
	localparam logic [2:0] EV_RCV      = 3'd5;
	localparam logic [2:0] EV_BYTE     = 3'd6;

	localparam logic [7:0]  CODE_NONE     = 8'hFF;
	localparam int          MIN_LEN       = 3;
	localparam logic [15:0] RESET_TIMEOUT = 16'd10;
	localparam int          RESULT_CAP    = 64;
endpackage

/* hw/rtl/learned_command_record_store.sv */
// learned_command_record_store: top level, sequencer over the record memory
// depends on lcrs_pkg and lcrs_store
//
// channel  | signals                     | handshake
// command  | start, busy, cmd            | taken when start & !busy
// result   | result_valid, result        | one-cycle strobe, no stall
// config   | cfg_valid, cfg_ready, cfg_data | taken when valid & ready
//
// a packet byte without last, a tick or a start passes DEC and returns to idle
// a packet end walks the list one memory read per cycle through RLEN, GLEN,
// GCODE per record, CMP, WR or RPL per byte; delete adds a full-list check
// reset and every wipe sweep the memory to zero, busy meanwhile
// results leave one per cycle; the receiver cannot stall them
module learned_command_record_store #(
	parameter int STORE_BYTES = 256,
	parameter int MAX_PACKET  = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  lcrs_pkg::in_item_t    cmd,
	output logic                  result_valid,
	output lcrs_pkg::out_item_t   result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [15:0]           cfg_data
);
	import lcrs_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);
	localparam int PW = $clog2(MAX_PACKET + 1);
	localparam int BW = (MAX_PACKET > 1) ? $clog2(MAX_PACKET) : 1;
	localparam int OW = (AW + 1 > 8) ? AW + 1 : 8;

	// states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_RLEN  = 4'd2; // issue length read
	localparam logic [3:0] S_GLEN  = 4'd3; // length arrives, issue code read
	localparam logic [3:0] S_GCODE = 4'd4; // code arrives, decide
	localparam logic [3:0] S_CMP   = 4'd5; // compare data bytes
	localparam logic [3:0] S_WR    = 4'd6; // write a record
	localparam logic [3:0] S_RPL   = 4'd7; // replay bytes
	localparam logic [3:0] S_OUT   = 4'd8;
	localparam logic [3:0] S_WIPE  = 4'd9;
	localparam logic [3:0] S_CLR   = 4'd10;

	// walk purposes
	localparam logic [1:0] W_MATCH = 2'd0;
	localparam logic [1:0] W_REC   = 2'd1;
	localparam logic [1:0] W_DEL   = 2'd2;
	localparam logic [1:0] W_EMPTY = 2'd3;

	logic [3:0]     st_q;
	logic [1:0]     walk_q;
	in_item_t       cmd_q;
	logic [15:0]    tmo_q, cnt_q;
	logic [7:0]     armed_q;
	logic [PW-1:0]  plen_q, n_q;
	logic [7:0]     pbuf [MAX_PACKET];
	logic [7:0]     pb_q;
	logic [AW:0]    off_q;
	logic [7:0]     len_q, code_q;
	logic [OW-1:0]  ord_q;
	logic [8:0]     k_q;
	logic           found_q;
	out_item_t      res_q;
	logic           rv_q;

	logic [AW:0]    rd_addr, wr_addr;
	logic [7:0]     rd_data, wr_data;
	logic           wr_en, clr_start, clr_busy;

	lcrs_store #(.STORE_BYTES(STORE_BYTES), .AW(AW)) u_store (
		.clk, .arst_n, .clr_start, .clr_busy,
		.rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
	);

	assign busy      = (st_q != S_IDLE) || clr_busy;
	assign cfg_ready = 1'b1;
	assign result_valid = rv_q;
	assign result       = res_q;

	logic [AW+9:0] next_off;
	logic [AW+9:0] fit_end;
	assign next_off = (AW+10)'(off_q) + (AW+10)'(len_q) + (AW+10)'(2);
	assign fit_end  = (AW+10)'(off_q) + (AW+10)'(2) + (AW+10)'(n_q);

	// memory address and write control
	always_comb begin
		rd_addr = off_q;
		wr_en   = 1'b0;
		wr_addr = off_q;
		wr_data = 8'd0;
		clr_start = (st_q == S_WIPE);
		unique case (st_q)
			S_GLEN:  rd_addr = off_q + 1'b1;
			S_CMP, S_RPL: rd_addr = off_q + (AW+1)'(2) + (AW+1)'(k_q);
			default: rd_addr = off_q;
		endcase
		if (st_q == S_WR) begin
			wr_en = 1'b1;
			if (k_q == 9'd0) wr_data = 8'(n_q);
			else if (k_q == 9'd1) wr_data = armed_q;
			else wr_data = pb_q;
			wr_addr = off_q + (AW+1)'(k_q);
		end else if (st_q == S_GCODE && walk_q == W_DEL && len_q != 8'd0 &&
				(cmd_q.delete_all || ord_q == OW'(cmd_q.record_number)) &&
				rd_data != CODE_NONE) begin
			wr_en   = 1'b1;
			wr_addr = off_q + 1'b1;
			wr_data = CODE_NONE;
		end
	end

	// packet buffer read for compare and copy
	logic [7:0] pidx;
	always_comb begin
		pidx = 8'd0;
		if (st_q == S_WR) pidx = 8'(k_q - 9'd1);
		else if (st_q == S_CMP) pidx = 8'(k_q);
		else if (st_q == S_GCODE) pidx = 8'd0;
	end

	always_ff @(posedge clk) begin
		if (st_q == S_DEC && cmd_q.mode == MODE_BYTE && plen_q < PW'(MAX_PACKET))
			pbuf[plen_q[BW-1:0]] <= cmd_q.data_byte;
		pb_q <= pbuf[pidx[BW-1:0]];
	end

	function automatic out_item_t mk(input logic [2:0] k, input logic [7:0] c,
			input logic [7:0] b, input logic l);
		out_item_t r;
		r.event_kind = k;
		r.event_code = c;
		r.out_byte   = b;
		r.last_out   = l;
		return r;
	endfunction

	logic cmp_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; walk_q <= W_MATCH;
			tmo_q <= RESET_TIMEOUT; cnt_q <= '0; armed_q <= CODE_NONE;
			plen_q <= '0; n_q <= '0; rv_q <= 1'b0;
			off_q <= '0; len_q <= '0; code_q <= '0; ord_q <= '0; k_q <= '0;
			found_q <= 1'b0; cmp_ok_q <= 1'b0;
			cmd_q <= '0; res_q <= '0;
		end else begin
			rv_q <= 1'b0;
			if (cfg_valid) tmo_q <= cfg_data;
			unique case (st_q)
				S_IDLE: if (start && !clr_busy) begin
					cmd_q <= cmd;
					st_q  <= S_DEC;
				end
				S_DEC: begin
					st_q  <= S_IDLE;
					off_q <= '0; ord_q <= '0; found_q <= 1'b0; k_q <= '0;
					priority case (cmd_q.mode)
						MODE_BYTE: begin
							if (plen_q < PW'(MAX_PACKET)) plen_q <= plen_q + 1'b1;
							if (cmd_q.last_byte) begin
								plen_q <= '0;
								n_q <= (plen_q < PW'(MAX_PACKET)) ? plen_q + 1'b1 : plen_q;
								if (((plen_q < PW'(MAX_PACKET)) ? plen_q + 1'b1 : plen_q)
										>= PW'(MIN_LEN)) begin
									walk_q <= W_MATCH; st_q <= S_RLEN;
								end
							end
						end
						MODE_START: begin
							armed_q <= {1'b0, cmd_q.code_value};
							cnt_q <= tmo_q;
						end
						MODE_DELETE: begin walk_q <= W_DEL; st_q <= S_RLEN; end
						MODE_REPLAY: begin walk_q <= W_MATCH; st_q <= S_RLEN; end
						MODE_TICK: if (armed_q != CODE_NONE) begin
							if (cnt_q <= 16'd1) begin
								res_q <= mk(EV_TIMEOUT, armed_q, 8'd0, 1'b1);
								rv_q <= 1'b1; armed_q <= CODE_NONE; cnt_q <= '0;
							end else cnt_q <= cnt_q - 1'b1;
						end
						default: st_q <= S_IDLE;
					endcase
				end
				S_RLEN: begin
					if (off_q >= (AW+1)'(STORE_BYTES)) begin
						len_q <= 8'd0; st_q <= S_GCODE;
						// end of store: treat as terminator but full for record
					end else st_q <= S_GLEN;
					if (walk_q == W_REC && fit_end > (AW+10)'(STORE_BYTES)) begin
						res_q <= mk(EV_FULL, armed_q, 8'd0, 1'b1); st_q <= S_OUT;
					end
				end
				S_GLEN: begin len_q <= rd_data; st_q <= S_GCODE; end
				S_GCODE: begin
					code_q <= rd_data; st_q <= S_RLEN; k_q <= '0;
					if (off_q >= (AW+1)'(STORE_BYTES) || len_q == 8'd0) begin
						// end of list
						priority if (walk_q == W_REC) begin
							if (off_q >= (AW+1)'(STORE_BYTES)) begin
								res_q <= mk(EV_FULL, armed_q, 8'd0, 1'b1); st_q <= S_OUT;
							end else st_q <= S_WR;
						end else if (walk_q == W_DEL) begin
							if (!found_q && !cmd_q.delete_all) begin
								res_q <= mk(EV_NOTFOUND, armed_q, 8'd0, 1'b1); st_q <= S_OUT;
							end else begin
								walk_q <= W_EMPTY; off_q <= '0; st_q <= S_RLEN;
							end
						end else if (walk_q == W_EMPTY) begin
							res_q <= mk(EV_OK, armed_q, 8'd0, 1'b1); st_q <= S_WIPE;
						end else if (cmd_q.mode == MODE_REPLAY) begin
							res_q <= mk(EV_NOTFOUND, armed_q, 8'd0, 1'b1); st_q <= S_OUT;
						end else if (armed_q == CODE_NONE) begin
							st_q <= S_IDLE;
						end else begin
							walk_q <= W_REC; off_q <= '0;
						end
					end else begin
						off_q <= next_off[AW:0];
						if (next_off > (AW+10)'(STORE_BYTES)) off_q <= (AW+1)'(STORE_BYTES);
						ord_q <= ord_q + 1'b1;
						priority if (walk_q == W_MATCH && cmd_q.mode == MODE_REPLAY) begin
							if (ord_q == OW'(cmd_q.record_number)) begin
								off_q <= off_q; st_q <= S_RPL;
							end
						end else if (walk_q == W_MATCH) begin
							if (rd_data != CODE_NONE && len_q == 8'(n_q)) begin
								off_q <= off_q; st_q <= S_CMP; cmp_ok_q <= 1'b1;
							end
						end else if (walk_q == W_REC) begin
							if (len_q == 8'(n_q) && rd_data == CODE_NONE) begin
								off_q <= off_q; st_q <= S_WR;
							end
						end else if (walk_q == W_DEL) begin
							if ((cmd_q.delete_all || ord_q == OW'(cmd_q.record_number)) &&
									rd_data != CODE_NONE) begin
								found_q <= 1'b1;
								if (!cmd_q.delete_all) begin
									walk_q <= W_EMPTY; off_q <= '0;
								end
							end
						end else begin
							// empty check: any live record ends it with ok
							if (rd_data != CODE_NONE) begin
								res_q <= mk(EV_OK, armed_q, 8'd0, 1'b1); st_q <= S_OUT;
							end
						end
					end
				end
				S_CMP: begin
					// pipelined: issue read k, check read k-1
					if (k_q != 9'd0 && rd_data != pb_q) cmp_ok_q <= 1'b0;
					if (k_q == 9'(n_q) + 9'd1 || (k_q != 9'd0 && rd_data != pb_q)) begin
						if (k_q == 9'(n_q) + 9'd1 && cmp_ok_q) begin
							st_q <= S_OUT;
							if (armed_q == CODE_NONE) res_q <= mk(EV_RCV, code_q, 8'd0, 1'b1);
							else begin
								res_q <= mk(EV_DUP, code_q, 8'd0, 1'b1);
								armed_q <= CODE_NONE; cnt_q <= '0;
							end
						end else begin
							off_q <= next_off[AW:0];
							if (next_off > (AW+10)'(STORE_BYTES))
								off_q <= (AW+1)'(STORE_BYTES);
							st_q <= S_RLEN;
						end
					end
					k_q <= k_q + 1'b1;
				end
				S_WR: begin
					k_q <= k_q + 1'b1;
					if (k_q == 9'(n_q) + 9'd1) begin
						res_q <= mk(EV_OK, armed_q, 8'd0, 1'b1); st_q <= S_OUT;
					end
				end
				S_RPL: begin
					k_q <= k_q + 1'b1;
					if (k_q != 9'd0) begin
						rv_q <= 1'b1;
						res_q <= mk(EV_BYTE, code_q, rd_data,
							k_q == 9'((len_q < 8'(RESULT_CAP)) ? len_q : 8'(RESULT_CAP)));
						if (k_q == 9'((len_q < 8'(RESULT_CAP)) ? len_q : 8'(RESULT_CAP)))
							st_q <= S_IDLE;
					end
				end
				S_OUT: begin
					rv_q <= 1'b1; st_q <= S_IDLE;
					if (res_q.event_kind == EV_OK || res_q.event_kind == EV_FULL)
						if (cmd_q.mode == MODE_BYTE) begin
							armed_q <= CODE_NONE; cnt_q <= '0;
						end
				end
				S_WIPE: begin rv_q <= 1'b1; st_q <= S_CLR; end
				S_CLR: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_one_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		rv_q && res_q.last_out |=> !rv_q || res_q.event_kind == EV_BYTE)
		else $error("result after final item");
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_OUT |-> busy) else $error("idle during result");
	a_no_wr_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !(st_q == S_WR)) else $error("write during wipe");
endmodule

/* hw/rtl/lcrs_store.sv */
// lcrs_store: record byte memory, one read and one write port, clearing sweep
// depends on lcrs_pkg
module lcrs_store #(
	parameter int STORE_BYTES = 256,
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr_start,
	output logic          clr_busy,
	input  logic [AW:0]   rd_addr,
	output logic [7:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW:0]   wr_addr,
	input  logic [7:0]    wr_data
);
	import lcrs_pkg::*;

	logic [7:0]    mem [STORE_BYTES];
	logic [7:0]    rd_q;
	logic          oob_q;
	logic [AW:0]   clr_q;
	logic          clr_on_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_on_q <= 1'b1;
			clr_q    <= '0;
		end else if (clr_start) begin
			clr_on_q <= 1'b1;
			clr_q    <= '0;
		end else if (clr_on_q) begin
			if (clr_q == (AW+1)'(STORE_BYTES - 1)) clr_on_q <= 1'b0;
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_on_q)
			mem[clr_q[AW-1:0]] <= 8'd0;
		else if (wr_en && wr_addr < (AW+1)'(STORE_BYTES))
			mem[wr_addr[AW-1:0]] <= wr_data;
		rd_q  <= mem[rd_addr[AW-1:0]];
		oob_q <= rd_addr >= (AW+1)'(STORE_BYTES);
	end

	assign rd_data  = oob_q ? 8'd0 : rd_q;
	assign clr_busy = clr_on_q;
endmodule
